FILE: rtl/speed_pi_controller_assert.svh
// ---------------------------------------------------------------------------
// speed_pi_controller assertion macros
// Shared concurrent assertion forms used by the speed loop controller.
// ---------------------------------------------------------------------------
`ifndef SPEED_PI_CONTROLLER_ASSERT_SVH
`define SPEED_PI_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spc_pkg.sv
// ---------------------------------------------------------------------------
// spc_pkg
// Types and constants shared by the speed loop PI controller modules.
// ---------------------------------------------------------------------------
package spc_pkg;

    // integral clamp and gain scaling
    localparam int INTEGRAL_LIMIT = 10000;
    localparam int GAIN_FRAC_BITS = 8;

    // divide by five as multiply by ceil(2^21 / 5) then shift by 21
    localparam logic signed [19:0] RECIP_FIVE  = 20'sd419431;
    localparam int                 RECIP_SHIFT = 21;

    // field widths
    localparam int SPEED_W = 15;
    localparam int CFG_W   = 16;
    localparam int RAW_W   = 18;
    localparam int NUM_W   = 20;
    localparam int MAG_W   = 19;
    localparam int INTEG_W = 15;
    localparam int MUL_W   = 20;
    localparam int PROD_W  = 40;
    localparam int ACC_W   = 35;
    localparam int DRIVE_W = 16;
    localparam int ADDR_W  = 4;

    // register indexes
    typedef enum logic [1:0] {
        REG_SETPOINT = 2'd0,
        REG_PROP     = 2'd1,
        REG_INTEG    = 2'd2
    } reg_idx_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUM,
        ST_RECIP,
        ST_PROP,
        ST_INTEG,
        ST_DONE
    } state_t;

    // commands from sequencer to datapath
    typedef struct packed {
        logic load_in;
        logic load_num;
        logic load_filt;
        logic acc_first;
        logic acc_add;
        logic commit;
    } cmd_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

FILE: rtl/spc_regs.sv
// ---------------------------------------------------------------------------
// spc_regs
// APB register file holding setpoint and the two loop gains.
// ---------------------------------------------------------------------------
module spc_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spc_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic signed [spc_pkg::CFG_W-1:0]    setpoint,
    output logic signed [spc_pkg::CFG_W-1:0]    kp,
    output logic signed [spc_pkg::CFG_W-1:0]    ki
);
    import spc_pkg::*;

    logic signed [CFG_W-1:0] setpoint_reg, setpoint_next;
    logic signed [CFG_W-1:0] kp_reg, kp_next;
    logic signed [CFG_W-1:0] ki_reg, ki_next;
    reg_idx_t                idx;
    logic                    wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;

    // write decode
    always_comb begin
        setpoint_next = setpoint_reg;
        kp_next       = kp_reg;
        ki_next       = ki_reg;
        if (wr_en) begin
            unique case (idx)
                REG_SETPOINT: setpoint_next = pwdata[CFG_W-1:0];
                REG_PROP:     kp_next       = pwdata[CFG_W-1:0];
                REG_INTEG:    ki_next       = pwdata[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= '0;
            kp_reg       <= '0;
            ki_reg       <= '0;
        end else begin
            setpoint_reg <= setpoint_next;
            kp_reg       <= kp_next;
            ki_reg       <= ki_next;
        end
    end

    // read decode, sign extended to the bus
    always_comb begin
        unique case (idx)
            REG_SETPOINT: prdata = {{(32-CFG_W){setpoint_reg[CFG_W-1]}}, setpoint_reg};
            REG_PROP:     prdata = {{(32-CFG_W){kp_reg[CFG_W-1]}}, kp_reg};
            REG_INTEG:    prdata = {{(32-CFG_W){ki_reg[CFG_W-1]}}, ki_reg};
            default:      prdata = '0;
        endcase
    end

    assign setpoint = setpoint_reg;
    assign kp       = kp_reg;
    assign ki       = ki_reg;

endmodule

FILE: rtl/spc_ctrl.sv
// ---------------------------------------------------------------------------
// spc_ctrl
// Sequencer stepping one request through filter, gains and output.
// ---------------------------------------------------------------------------
module spc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  spc_pkg::sts_t   sts,
    output spc_pkg::cmd_t   cmd
);
    import spc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_NUM;
                end
            end
            ST_NUM: begin
                cmd.load_num = 1'b1;
                state_next   = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.load_filt = 1'b1;
                state_next    = ST_PROP;
            end
            ST_PROP: begin
                cmd.acc_first = 1'b1;
                state_next    = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/spc_dp.sv
// ---------------------------------------------------------------------------
// spc_dp
// Datapath: error filter, shared multiplier, accumulator, integral, output.
// ---------------------------------------------------------------------------
module spc_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  spc_pkg::cmd_t                       cmd,
    output spc_pkg::sts_t                       sts,
    input  logic signed [spc_pkg::CFG_W-1:0]    setpoint,
    input  logic signed [spc_pkg::CFG_W-1:0]    kp,
    input  logic signed [spc_pkg::CFG_W-1:0]    ki,
    input  logic signed [spc_pkg::SPEED_W-1:0]  left_speed,
    input  logic signed [spc_pkg::SPEED_W-1:0]  right_speed,
    input  logic                                run_enable,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [spc_pkg::DRIVE_W-1:0]  drive
);
    import spc_pkg::*;

    localparam logic signed [ACC_W-1:0]   RND_BIAS  = ACC_W'((1 << GAIN_FRAC_BITS) - 1);
    localparam int                        DSH_W     = ACC_W - GAIN_FRAC_BITS;
    localparam logic signed [DSH_W-1:0]   DRIVE_MAX = DSH_W'(32767);
    localparam logic signed [DSH_W-1:0]   DRIVE_MIN = -DSH_W'(32768);
    localparam logic signed [MAG_W:0]     LIM_POS   = (MAG_W+1)'(INTEGRAL_LIMIT);
    localparam logic signed [MAG_W:0]     LIM_NEG   = -(MAG_W+1)'(INTEGRAL_LIMIT);

    // state kept across requests
    logic signed [RAW_W-1:0]   prev_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    // per-request working registers
    logic signed [RAW_W-1:0]   raw_reg;
    logic                      run_reg;
    logic                      neg_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic signed [RAW_W-1:0]   filt_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0] drive_reg;

    logic signed [RAW_W-1:0]   raw_next;
    logic signed [NUM_W-1:0]   num;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [RAW_W-2:0]          quot;
    logic signed [RAW_W-1:0]   filt_next;
    logic signed [ACC_W-1:0]   acc_biased;
    logic signed [DSH_W-1:0]   dsh;
    logic signed [DRIVE_W-1:0] drive_sat;
    logic signed [MAG_W:0]     isum;
    logic signed [INTEG_W-1:0] integ_next;

    // raw error from setpoint and wheel sum
    assign raw_next = RAW_W'(setpoint) - RAW_W'(left_speed) - RAW_W'(right_speed);

    // filter numerator raw + 4*prev, the /5 gives (2*raw + 8*prev) / 10
    assign num = NUM_W'(raw_reg) + {prev_reg, 2'b00};

    // shared multiplier operand select
    always_comb begin
        if (cmd.load_filt) begin
            mul_a = signed'({1'b0, mag_reg});
            mul_b = RECIP_FIVE;
        end else if (cmd.acc_first) begin
            mul_a = MUL_W'(filt_reg);
            mul_b = MUL_W'(kp);
        end else begin
            mul_a = MUL_W'(integ_reg);
            mul_b = MUL_W'(ki);
        end
    end

    assign mul_p = mul_a * mul_b;

    // quotient magnitude, sign restored for truncation toward zero
    assign quot      = mul_p[RECIP_SHIFT +: (RAW_W-1)];
    assign filt_next = neg_reg ? -signed'({1'b0, quot}) : signed'({1'b0, quot});

    // scale down with truncation toward zero, then saturate
    assign acc_biased = acc_reg + (acc_reg[ACC_W-1] ? RND_BIAS : '0);
    assign dsh        = acc_biased[ACC_W-1:GAIN_FRAC_BITS];

    always_comb begin
        if (dsh > DRIVE_MAX) begin
            drive_sat = DRIVE_W'(DRIVE_MAX);
        end else if (dsh < DRIVE_MIN) begin
            drive_sat = DRIVE_W'(DRIVE_MIN);
        end else begin
            drive_sat = dsh[DRIVE_W-1:0];
        end
    end

    // integral update with anti-windup clamp, cleared when stopped
    assign isum = (MAG_W+1)'(integ_reg) + (MAG_W+1)'(filt_reg);

    always_comb begin
        if (!run_reg) begin
            integ_next = '0;
        end else if (isum > LIM_POS) begin
            integ_next = INTEG_W'(LIM_POS);
        end else if (isum < LIM_NEG) begin
            integ_next = INTEG_W'(LIM_NEG);
        end else begin
            integ_next = isum[INTEG_W-1:0];
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            raw_reg <= raw_next;
            run_reg <= run_enable;
        end
        if (cmd.load_num) begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        end
        if (cmd.load_filt) begin
            filt_reg <= filt_next;
        end
        if (cmd.acc_first) begin
            acc_reg <= mul_p[ACC_W-1:0];
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + mul_p[ACC_W-1:0];
        end
        if (cmd.commit) begin
            drive_reg <= drive_sat;
        end
    end

    // loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            integ_reg <= '0;
        end else if (cmd.commit) begin
            prev_reg  <= filt_reg;
            integ_reg <= integ_next;
        end
    end

    // output handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.out_busy = out_valid_reg & ~out_ready;
    assign out_valid    = out_valid_reg;
    assign drive        = drive_reg;

endmodule

FILE: rtl/speed_pi_controller.sv
// ---------------------------------------------------------------------------
// speed_pi_controller
// Speed loop PI controller with low-pass filtered error and integral clamp.
// ---------------------------------------------------------------------------
//  channel   direction  ports                              content
//  s_        in         s_tvalid/s_tready/s_tdata/s_tuser  wheel speeds, run flag
//  m_        out        m_tvalid/m_tready/m_tdata          drive value
//  apb       in/out     psel/penable/pwrite/paddr          setpoint and gains
//
// the drive reaches the output register once the sequencer has stepped the
// single shared multiplier through the divide by five, the proportional
// product and the integral product; no new request is taken before the
// last one has been committed to the output register.
// s_tready is high only while the sequencer is idle; a pending result in the
// output register holds the last step until the consumer takes it.
// reset is synchronous, active low, and clears the filter and integral state.
// ---------------------------------------------------------------------------
module speed_pi_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // left_speed[14:0], right_speed[29:15]
    input  logic                            s_tuser,   // run_enable
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // drive[15:0]
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spc_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import spc_pkg::*;

    `include "speed_pi_controller_assert.svh"

    logic signed [CFG_W-1:0]   setpoint, kp, ki;
    logic signed [DRIVE_W-1:0] drive;
    cmd_t                      cmd;
    sts_t                      sts;

    spc_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .setpoint (setpoint),
        .kp       (kp),
        .ki       (ki)
    );

    spc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .setpoint    (setpoint),
        .kp          (kp),
        .ki          (ki),
        .left_speed  (s_tdata[SPEED_W-1:0]),
        .right_speed (s_tdata[2*SPEED_W-1:SPEED_W]),
        .run_enable  (s_tuser),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .drive       (drive)
    );

    assign m_tdata = drive;

    // checks on sequencing and output hand-off
    `SPC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted request did not make the block busy")
    `SPC_ASSERT_SAME(a_commit_slot_free, aclk, aresetn, cmd.commit, !sts.out_busy, "result committed over a pending result")
    `SPC_ASSERT_NEXT(a_commit_valid, aclk, aresetn, cmd.commit, m_tvalid, "committed result not presented")

endmodule

FILE: tb/speed_pi_controller_test.sv
// ---------------------------------------------------------------------------
// speed_pi_controller_test
// Self-checking bench for the speed loop PI controller. Wheel speed requests
// go in over the input stream and every drive value that comes out is
// checked against an in-bench model of the filter, gains, saturation and
// integral clamp. Gains and setpoint are rewritten over APB while the block
// is idle, and both stream sides idle and stall at random in several phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module speed_pi_controller_test;
    import spc_pkg::*;

    localparam int  SETTLE_CYCLES = 12;
    localparam int  MAX_REPORTS   = 10;
    localparam int  SPEED_MIN     = -16384;
    localparam int  SPEED_MAX     = 16383;
    localparam int  UNMAPPED_IDX  = 3;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [31:0]              s_tdata = '0;   // left_speed[14:0], right_speed[29:15]
    logic                     s_tuser = 1'b0; // run_enable
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [15:0]              m_tdata;        // drive[15:0]
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    // controller model state and register copies
    logic signed [RAW_W-1:0]   model_filt_prev;
    logic signed [INTEG_W-1:0] model_integral;
    logic signed [CFG_W-1:0]   model_setpoint;
    logic signed [CFG_W-1:0]   model_prop_gain;
    logic signed [CFG_W-1:0]   model_integ_gain;

    logic signed [DRIVE_W-1:0] expected_drive[$];
    int                        mismatch_count = 0;
    int                        src_idle_pct = 0;
    int                        sink_stall_pct = 0;

    speed_pi_controller u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // generous overall limit
    initial begin
        #6ms;
        $display("speed_pi_controller_test NOT OK");
        $finish;
    end

    // one controller period: drive from the old integral, then update state
    function automatic logic signed [DRIVE_W-1:0] predict_drive(
        input logic signed [SPEED_W-1:0] left_spd,
        input logic signed [SPEED_W-1:0] right_spd,
        input logic                      run_en
    );
        longint raw_err;
        longint filt_err;
        longint acc;
        longint drv;
        longint integ_next;
        raw_err  = longint'(model_setpoint) - (longint'(left_spd) + longint'(right_spd));
        filt_err = (2 * raw_err + 8 * longint'(model_filt_prev)) / 10;
        acc      = longint'(model_prop_gain) * filt_err
                 + longint'(model_integ_gain) * longint'(model_integral);
        drv      = acc / (longint'(1) << GAIN_FRAC_BITS);
        if (drv > 32767)
            drv = 32767;
        if (drv < -32768)
            drv = -32768;
        integ_next = longint'(model_integral) + filt_err;
        if (integ_next > INTEGRAL_LIMIT)
            integ_next = INTEGRAL_LIMIT;
        if (integ_next < -INTEGRAL_LIMIT)
            integ_next = -INTEGRAL_LIMIT;
        if (!run_en)
            integ_next = 0;
        model_integral  = integ_next[INTEG_W-1:0];
        model_filt_prev = filt_err[RAW_W-1:0];
        return drv[DRIVE_W-1:0];
    endfunction

    // random receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= (int'($urandom_range(0, 99)) >= sink_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        logic signed [DRIVE_W-1:0] exp_drv;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_drive.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected drive result %0d", $signed(m_tdata));
                mismatch_count++;
            end else begin
                exp_drv = expected_drive.pop_front();
                if (m_tdata !== exp_drv) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("drive mismatch: expected %0d actual %0d",
                                 exp_drv, $signed(m_tdata));
                    mismatch_count++;
                end
            end
        end
    end

    // send one speed request, prediction taken at acceptance
    task automatic send_speeds(
        input logic signed [SPEED_W-1:0] left_spd,
        input logic signed [SPEED_W-1:0] right_spd,
        input logic                      run_en
    );
        if (int'($urandom_range(0, 99)) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (int'($urandom_range(0, 99)) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, right_spd, left_spd};
        s_tuser  <= run_en;
        do @(posedge aclk); while (!s_tready);
        expected_drive.push_back(predict_drive(left_spd, right_spd, run_en));
    endtask

    // hold off until every expected drive has come back and the block is idle
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // apb write, setup then access
    task automatic write_register(input int idx, input logic signed [CFG_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= {{(32 - CFG_W){value[CFG_W-1]}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SETPOINT: model_setpoint   = value;
            REG_PROP:     model_prop_gain  = value;
            REG_INTEG:    model_integ_gain = value;
            default: ;
        endcase
    endtask

    task automatic set_loop(input logic signed [CFG_W-1:0] setpoint,
                            input logic signed [CFG_W-1:0] prop_gain,
                            input logic signed [CFG_W-1:0] integ_gain);
        settle_block();
        write_register(REG_SETPOINT, setpoint);
        write_register(REG_PROP, prop_gain);
        write_register(REG_INTEG, integ_gain);
    endtask

    // reset values give zero drive whatever the speeds
    task automatic test_reset_defaults();
        send_speeds(15'sh3FFF, 15'sh3FFF, 1'b1);
        send_speeds(15'sh4000, 15'sh4000, 1'b1);
        send_speeds(15'sh4000, 15'sh3FFF, 1'b0);
    endtask

    // each register reaches the loop, an unmapped index is dropped
    task automatic test_register_map();
        set_loop(16'sd1000, 16'sd256, 16'sd0);
        send_speeds(15'sd100, 15'sd200, 1'b1);
        settle_block();
        write_register(UNMAPPED_IDX, 16'sh7FFF);
        send_speeds(15'sd100, 15'sd200, 1'b1);
        settle_block();
        write_register(REG_INTEG, 16'sd128);
        send_speeds(-15'sd50, 15'sd75, 1'b1);
        send_speeds(15'sd0, 15'sd0, 1'b1);
    endtask

    // large errors with extreme gains push drive into both rails
    task automatic test_drive_saturation();
        set_loop(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_speeds(15'sh4000, 15'sh4000, 1'b1);
        send_speeds(15'sh4000, 15'sh4000, 1'b1);
        set_loop(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_speeds(15'sh3FFF, 15'sh3FFF, 1'b1);
        send_speeds(15'sh3FFF, 15'sh3FFF, 1'b1);
        send_speeds(15'sh4000, 15'sh3FFF, 1'b0);
    endtask

    // integral runs into both clamps, then stop clears it
    task automatic test_integral_clamp();
        set_loop(16'sd0, 16'sd0, 16'sd256);
        repeat (3) send_speeds(15'sh4000, 15'sh4000, 1'b1);
        repeat (4) send_speeds(15'sh3FFF, 15'sh3FFF, 1'b1);
        send_speeds(15'sh3FFF, 15'sh3FFF, 1'b0);
        send_speeds(15'sd0, 15'sd0, 1'b1);
    endtask

    function automatic logic signed [CFG_W-1:0] pick_gain();
        int v;
        case ($urandom_range(0, 7))
            0: v = -32768;
            1: v = 32767;
            default: v = int'($urandom_range(0, 1535)) - 768;
        endcase
        return v[CFG_W-1:0];
    endfunction

    function automatic logic signed [CFG_W-1:0] pick_setpoint();
        int v;
        case ($urandom_range(0, 7))
            0: v = -32768;
            1: v = 32767;
            default: v = int'($urandom_range(0, 20000)) - 10000;
        endcase
        return v[CFG_W-1:0];
    endfunction

    // speed near the share of the setpoint, or anywhere in range
    function automatic logic signed [SPEED_W-1:0] pick_speed();
        int v;
        if ($urandom_range(0, 4) == 0) begin
            v = int'($urandom_range(0, 32767));
            return v[SPEED_W-1:0];
        end
        v = int'(model_setpoint) / 2 + int'($urandom_range(0, 600)) - 300;
        if (v > SPEED_MAX)
            v = SPEED_MAX;
        if (v < SPEED_MIN)
            v = SPEED_MIN;
        return v[SPEED_W-1:0];
    endfunction

    // random loop settings and speeds through each idling phase
    task automatic test_random_traffic();
        int idle_tab[4]  = '{0, 65, 0, 8};
        int stall_tab[4] = '{0, 0, 65, 8};
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = idle_tab[ph];
            sink_stall_pct = stall_tab[ph];
            for (int cfg = 0; cfg < 2; cfg++) begin
                set_loop(pick_setpoint(), pick_gain(), pick_gain());
                for (int n = 0; n < 70; n++)
                    send_speeds(pick_speed(), pick_speed(), $urandom_range(0, 19) != 0);
            end
        end
    endtask

    initial begin
        model_filt_prev  = '0;
        model_integral   = '0;
        model_setpoint   = '0;
        model_prop_gain  = '0;
        model_integ_gain = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_register_map();
        test_drive_saturation();
        test_integral_clamp();
        test_random_traffic();

        settle_block();
        if (mismatch_count == 0 && expected_drive.size() == 0) begin
            $display("speed_pi_controller_test OK");
        end else begin
            $display("speed_pi_controller_test NOT OK");
        end
        $finish;
    end

endmodule
